[rtl/rom_ram_bank_controller_core_defines.svh]
// ----------------------------------------------------------------------------
// Bank controller assertion macros
// Shared property shorthands for the bank controller modules.
// ----------------------------------------------------------------------------
`ifndef ROM_RAM_BANK_CONTROLLER_CORE_DEFINES_SVH
`define ROM_RAM_BANK_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RRBC_ASSERT_IMPL(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("rrbc assertion failed");

// Next-cycle implication, disabled during reset.
`define RRBC_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("rrbc assertion failed");

`endif

[rtl/rrbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller package
// Widths, codes and request types shared by the bank controller modules.
// ----------------------------------------------------------------------------
package rrbc_pkg;

    localparam int ROM_ADDR_BITS = 21;
    localparam int RAM_ADDR_BITS = 15;
    localparam int ROM_DEPTH     = 1 << ROM_ADDR_BITS;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = 1;

    typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;
    typedef logic [RAM_ADDR_BITS-1:0] ram_addr_t;
    typedef logic [7:0]               byte_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
    localparam logic [2:0] REGION_BANK_LOW   = 3'd1;
    localparam logic [2:0] REGION_BANK_HIGH  = 3'd2;
    localparam logic [2:0] REGION_MODE       = 3'd3;
    localparam logic [2:0] REGION_RAM        = 3'd5;

    localparam logic [1:0] ROM_FIXED_QUARTER  = 2'd0;
    localparam logic [1:0] ROM_SWITCH_QUARTER = 2'd1;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam byte_t      UNMAPPED_BYTE  = 8'hFF;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ROM_RD,
        CMD_ROM_WR,
        CMD_RAM_RD,
        CMD_RAM_WR,
        CMD_FF_RD
    } mem_cmd_t;

    typedef struct packed {
        mem_cmd_t  cmd;
        rom_addr_t addr;
        byte_t     data;
    } mem_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

[rtl/rrbc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data registered and held when idle.
// ----------------------------------------------------------------------------
module rrbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rrbc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller front end
// Accepts items, updates bank registers and maps accesses to memory requests.
// ----------------------------------------------------------------------------
module rrbc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [15:0]           bus_address,
    input  logic [20:0]           load_address,
    input  logic [7:0]            write_data,
    input  rrbc_pkg::queue_status_t q_status,
    input  rrbc_pkg::back_status_t  b_status,
    output logic                  push,
    output rrbc_pkg::mem_req_t    push_req
);
    import rrbc_pkg::*;

    logic [6:0] rom_bank_reg,  rom_bank_next;
    logic [1:0] ram_bank_reg,  ram_bank_next;
    logic       mode_reg,      mode_next;
    logic       ram_en_reg,    ram_en_next;
    logic       accept;
    logic [2:0] region;
    logic [4:0] low_bits;
    logic [6:0] eff_bank;
    mem_req_t   req;

    assign in_stall = q_status.full || b_status.clearing;
    assign accept   = in_valid && !in_stall;
    assign region   = bus_address[15:13];
    assign low_bits = write_data[4:0];
    assign eff_bank = mode_reg ? rom_bank_reg : {2'b00, rom_bank_reg[4:0]};

    always_comb
    begin
        req.cmd  = CMD_NONE;
        req.addr = '0;
        req.data = write_data;
        case (operation)
            OP_READ:
            begin
                if (bus_address[15:14] == ROM_FIXED_QUARTER)
                begin
                    req.cmd  = CMD_ROM_RD;
                    req.addr = rom_addr_t'({7'd0, bus_address[13:0]});
                end
                else if (bus_address[15:14] == ROM_SWITCH_QUARTER)
                begin
                    req.cmd  = CMD_ROM_RD;
                    req.addr = rom_addr_t'({eff_bank, bus_address[13:0]});
                end
                else if (region == REGION_RAM && ram_en_reg)
                begin
                    req.cmd  = CMD_RAM_RD;
                    req.addr = rom_addr_t'(ram_addr_t'({ram_bank_reg, bus_address[12:0]}));
                end
                else
                begin
                    req.cmd = CMD_FF_RD;
                end
            end
            OP_WRITE:
            begin
                if (region == REGION_RAM && ram_en_reg)
                begin
                    req.cmd  = CMD_RAM_WR;
                    req.addr = rom_addr_t'(ram_addr_t'({ram_bank_reg, bus_address[12:0]}));
                end
            end
            OP_LOAD:
            begin
                req.cmd  = CMD_ROM_WR;
                req.addr = rom_addr_t'(load_address);
            end
            default:
            begin
                req.cmd = CMD_NONE;
            end
        endcase
    end

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        mode_next     = mode_reg;
        ram_en_next   = ram_en_reg;
        if (accept && operation == OP_WRITE)
        begin
            case (region)
                REGION_RAM_ENABLE:
                begin
                    ram_en_next = (write_data[3:0] == RAM_ENABLE_KEY);
                end
                REGION_BANK_LOW:
                begin
                    rom_bank_next = {rom_bank_reg[6:5],
                                     (low_bits == 5'd0) ? 5'd1 : low_bits};
                end
                REGION_BANK_HIGH:
                begin
                    if (mode_reg)
                    begin
                        rom_bank_next = {write_data[1:0], rom_bank_reg[4:0]};
                    end
                    else
                    begin
                        ram_bank_next = write_data[1:0];
                    end
                end
                REGION_MODE:
                begin
                    mode_next = (write_data == 8'd0);
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= 7'd1;
            ram_bank_reg <= 2'd0;
            mode_reg     <= 1'b1;
            ram_en_reg   <= 1'b0;
        end
        else
        begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            mode_reg     <= mode_next;
            ram_en_reg   <= ram_en_next;
        end
    end

    assign push     = accept && (req.cmd != CMD_NONE);
    assign push_req = req;

endmodule

[rtl/rrbc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller request queue
// Short FIFO of memory requests between front end and back end.
// ----------------------------------------------------------------------------
module rrbc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rrbc_pkg::mem_req_t      push_req,
    input  logic                    pop,
    output rrbc_pkg::mem_req_t      head,
    output rrbc_pkg::queue_status_t status
);
    import rrbc_pkg::*;

    mem_req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]    count_reg,  count_next;

    assign status.full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rrbc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank controller back end
// Clears RAM after reset, runs memory requests and drives the result register.
// ----------------------------------------------------------------------------
`include "rom_ram_bank_controller_core_defines.svh"

module rrbc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rrbc_pkg::mem_req_t      head,
    input  rrbc_pkg::queue_status_t q_status,
    output logic                    pop,
    output rrbc_pkg::back_status_t  b_status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              read_data
);
    import rrbc_pkg::*;

    logic      clear_active_reg, clear_active_next;
    ram_addr_t clr_addr_reg,     clr_addr_next;
    logic      s1_valid_reg,     s1_valid_next;
    mem_cmd_t  s1_cmd_reg;
    logic      out_valid_reg,    out_valid_next;
    byte_t     out_data_reg;
    logic      is_rd;
    logic      s1_move;
    logic      ram_en, ram_we, rom_en, rom_we;
    ram_addr_t ram_addr;
    byte_t     ram_wdata, ram_rdata, rom_rdata, s1_data;

    assign is_rd   = (head.cmd == CMD_ROM_RD) || (head.cmd == CMD_RAM_RD)
                     || (head.cmd == CMD_FF_RD);
    assign s1_move = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop     = !q_status.empty && !clear_active_reg
                     && (!is_rd || !s1_valid_reg || s1_move);

    assign ram_en    = clear_active_reg
                       || (pop && (head.cmd == CMD_RAM_RD || head.cmd == CMD_RAM_WR));
    assign ram_we    = clear_active_reg || (head.cmd == CMD_RAM_WR);
    assign ram_addr  = clear_active_reg ? clr_addr_reg : ram_addr_t'(head.addr);
    assign ram_wdata = clear_active_reg ? 8'd0 : head.data;
    assign rom_en    = pop && (head.cmd == CMD_ROM_RD || head.cmd == CMD_ROM_WR);
    assign rom_we    = (head.cmd == CMD_ROM_WR);

    rrbc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rrbc_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .clk   (clk),
        .en    (rom_en),
        .we    (rom_we),
        .addr  (head.addr),
        .wdata (head.data),
        .rdata (rom_rdata)
    );

    always_comb
    begin
        case (s1_cmd_reg)
            CMD_ROM_RD: s1_data = rom_rdata;
            CMD_RAM_RD: s1_data = ram_rdata;
            default:    s1_data = UNMAPPED_BYTE;
        endcase
    end

    always_comb
    begin
        clear_active_next = clear_active_reg;
        clr_addr_next     = clr_addr_reg;
        if (clear_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clear_active_next = 1'b0;
            end
        end
        if (pop && is_rd)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s1_move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_rd)
        begin
            s1_cmd_reg <= head.cmd;
        end
        if (s1_move)
        begin
            out_data_reg <= s1_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clr_addr_reg     <= clr_addr_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign b_status.clearing = clear_active_reg;
    assign out_valid         = out_valid_reg;
    assign read_data         = out_data_reg;

    `RRBC_ASSERT_IMPL(a_no_pop_while_clear, clk, rst_n, clear_active_reg, !pop)
    `RRBC_ASSERT_IMPL(a_read_slot_free, clk, rst_n, pop && is_rd, !s1_valid_reg || s1_move)
    `RRBC_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && out_valid_reg && out_stall,
                      s1_valid_reg)

endmodule

[rtl/rom_ram_bank_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROM/RAM bank controller
// Cartridge bank controller: bus reads and writes, ROM loads, banked memories.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     operation, bus_address, load_address,
//                                    write_data
//   out      out_valid / out_stall   read_data
//
// One item per cycle sustained while in_stall and out_stall stay low; a read
// passes the queue entry, the memory read, then the result register.
// After reset the RAM is swept to zero, one entry a cycle; in_stall stays
// high meanwhile.
// A stalled result holds the next read in the memory stage; writes and loads
// ahead of a waiting read keep flowing.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] bus_address,
    input  logic [20:0] load_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);
    import rrbc_pkg::*;

    logic          push;
    logic          pop;
    mem_req_t      push_req;
    mem_req_t      head;
    queue_status_t q_status;
    back_status_t  b_status;

    rrbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .bus_address  (bus_address),
        .load_address (load_address),
        .write_data   (write_data),
        .q_status     (q_status),
        .b_status     (b_status),
        .push         (push),
        .push_req     (push_req)
    );

    rrbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    rrbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .b_status  (b_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

endmodule
